/* rtl/core/fla_pkg.sv */
// Shared constants, codes and types of the free list allocator.
// No dependencies; fla_cell, fla_chain and the top level import it.
`default_nettype none

package fla_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int NCELL       = MAX_EXTENTS + 1;
  localparam int IDX_W       = $clog2(NCELL);
  localparam int CNT_W       = $clog2(NCELL + 1);
  localparam int DW          = 32;
  localparam int NSPLIT_W    = 6;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] STRAT_FIRST  = 2'd0;
  localparam logic [1:0] STRAT_BEST   = 2'd1;
  localparam logic [1:0] STRAT_BUDDY  = 2'd2;
  localparam logic [1:0] STRAT_HYBRID = 2'd3;

  localparam logic [1:0] CFG_STRATEGY = 2'd0;
  localparam logic [1:0] CFG_ALIGN    = 2'd1;
  localparam logic [1:0] CFG_MIN_REQ  = 2'd2;
  localparam logic [1:0] CFG_POOL     = 2'd3;

  localparam logic [3:0] MAX_ALIGN_LOG2 = 4'd12;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_INS,
    CMD_DEL,
    CMD_MERGE
  } cmd_op_e;

  typedef enum logic [1:0] {
    SCAN_FIRST,
    SCAN_BEST,
    SCAN_BUDDY,
    SCAN_REL
  } scan_mode_e;

  typedef struct packed {
    logic [DW-1:0] start;
    logic [DW-1:0] len;
  } ext_t;

  typedef struct packed {
    cmd_op_e          op;
    logic [IDX_W-1:0] idx;
    logic [DW-1:0]    start;
    logic [DW-1:0]    len;
  } cell_cmd_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [DW-1:0]    start;
    logic [DW-1:0]    len;
  } cand_t;

  typedef struct packed {
    scan_mode_e       mode;
    logic [DW-1:0]    key;
    logic [CNT_W-1:0] held;
  } scan_ctl_t;

  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] idx;
  } merge_t;

  localparam cell_cmd_t CMD_IDLE = '{op: CMD_NOP, idx: '0, start: '0, len: '0};

endpackage

`default_nettype wire

/* rtl/core/fla_if.sv */
// Valid/ready channel interfaces of the free list allocator.
// Request channel and result channel; no dependencies.
`default_nettype none

interface fla_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] req_bytes;
  logic [31:0] rel_start;

  modport source (output valid, opcode, req_bytes, rel_start, input ready);
  modport sink   (input valid, opcode, req_bytes, rel_start, output ready);
endinterface

interface fla_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] grant_start;
  logic [31:0] grant_bytes;
  logic [31:0] bytes_used;
  logic [31:0] bytes_free;
  logic [6:0]  extent_count;
  logic [31:0] grant_total;
  logic [31:0] release_total;

  modport source (output valid, status, grant_start, grant_bytes, bytes_used, bytes_free,
                  extent_count, grant_total, release_total, input ready);
  modport sink   (input valid, status, grant_start, grant_bytes, bytes_used, bytes_free,
                  extent_count, grant_total, release_total, output ready);
endinterface

`default_nettype wire

/* rtl/core/fla_cell.sv */
// One cell of the extent chain: holds one free extent and one step of the search.
// Depends on fla_pkg.
`default_nettype none

module fla_cell (
  input  logic                     clk_i,
  input  logic [fla_pkg::IDX_W-1:0] cell_idx_i,
  input  fla_pkg::scan_ctl_t       ctl_i,
  input  fla_pkg::cell_cmd_t       cmd_i,
  input  fla_pkg::ext_t            left_i,
  input  fla_pkg::ext_t            right_i,
  input  fla_pkg::cand_t           right_c0_i,
  input  fla_pkg::cand_t           right_c1_i,
  output fla_pkg::ext_t            ext_o,
  output fla_pkg::cand_t           c0_o,
  output fla_pkg::cand_t           c1_o,
  output logic                     touch_o
);
  import fla_pkg::*;

  ext_t  ext_q, ext_d;
  cand_t c0_q, c0_d, c1_q, c1_d;
  cand_t own, lft;
  logic  own_v, right_v;

  always_comb begin
    own_v   = CNT_W'(cell_idx_i) < ctl_i.held;
    right_v = ({1'b0, CNT_W'(cell_idx_i)} + (CNT_W+1)'(1)) < {1'b0, ctl_i.held};
    touch_o = own_v && right_v &&
              (({1'b0, ext_q.start} + {1'b0, ext_q.len}) == {1'b0, right_i.start});

    own.found = 1'b1;
    own.idx   = cell_idx_i;
    own.start = ext_q.start;
    own.len   = ext_q.len;

    lft.found = (cell_idx_i != '0);
    lft.idx   = cell_idx_i - IDX_W'(1);
    lft.start = left_i.start;
    lft.len   = left_i.len;

    ext_d = ext_q;
    case (cmd_i.op)
      CMD_WRITE: begin
        if (cell_idx_i == cmd_i.idx) ext_d = '{start: cmd_i.start, len: cmd_i.len};
      end
      CMD_INS: begin
        if (cell_idx_i == cmd_i.idx) ext_d = '{start: cmd_i.start, len: cmd_i.len};
        else if (cell_idx_i > cmd_i.idx) ext_d = left_i;
      end
      CMD_DEL: begin
        if (cell_idx_i >= cmd_i.idx) ext_d = right_i;
      end
      CMD_MERGE: begin
        if (cell_idx_i == cmd_i.idx) ext_d.len = ext_q.len + right_i.len;
        else if (cell_idx_i > cmd_i.idx) ext_d = right_i;
      end
      default: ext_d = ext_q;
    endcase

    c0_d = right_c0_i;
    c1_d = right_c1_i;
    case (ctl_i.mode)
      SCAN_FIRST: begin
        if (own_v && ext_q.len >= ctl_i.key) c0_d = own;
      end
      SCAN_BEST: begin
        if (own_v && ext_q.len >= ctl_i.key &&
            (!right_c0_i.found || ext_q.len <= right_c0_i.len)) c0_d = own;
      end
      SCAN_BUDDY: begin
        if (own_v && ext_q.len == ctl_i.key) c0_d = own;
        if (own_v && ext_q.len > ctl_i.key) c1_d = own;
      end
      SCAN_REL: begin
        if (own_v && ext_q.start > ctl_i.key) begin
          c0_d = lft;
          c1_d = own;
        end else if (own_v && !right_v) begin
          c0_d = own;
        end
      end
      default: begin
        c0_d = '0;
        c1_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ext_q <= ext_d;
    c0_q  <= c0_d;
    c1_q  <= c1_d;
  end

  assign ext_o = ext_q;
  assign c0_o  = c0_q;
  assign c1_o  = c1_q;

endmodule

`default_nettype wire

/* rtl/core/fla_chain.sv */
// Row of extent cells in address order, plus the first-touching-pair encoder.
// Depends on fla_pkg and fla_cell.
`default_nettype none

module fla_chain (
  input  logic               clk_i,
  input  fla_pkg::scan_ctl_t ctl_i,
  input  fla_pkg::cell_cmd_t cmd_i,
  output fla_pkg::cand_t     c0_o,
  output fla_pkg::cand_t     c1_o,
  output fla_pkg::merge_t    merge_o
);
  import fla_pkg::*;

  ext_t             ext [NCELL];
  cand_t            c0  [NCELL];
  cand_t            c1  [NCELL];
  logic [NCELL-1:0] touch;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ext_t  left, right;
    cand_t rc0, rc1;
    if (k == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = ext[k-1];
    end
    if (k == NCELL - 1) begin : g_tail
      assign right = '0;
      assign rc0   = '0;
      assign rc1   = '0;
    end else begin : g_mid
      assign right = ext[k+1];
      assign rc0   = c0[k+1];
      assign rc1   = c1[k+1];
    end

    fla_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(k)),
      .ctl_i      (ctl_i),
      .cmd_i      (cmd_i),
      .left_i     (left),
      .right_i    (right),
      .right_c0_i (rc0),
      .right_c1_i (rc1),
      .ext_o      (ext[k]),
      .c0_o       (c0[k]),
      .c1_o       (c1[k]),
      .touch_o    (touch[k])
    );
  end

  always_comb begin
    merge_o = '0;
    for (int k = NCELL - 1; k >= 0; k--) begin
      if (touch[k]) begin
        merge_o.any = 1'b1;
        merge_o.idx = IDX_W'(k);
      end
    end
  end

  assign c0_o = c0[0];
  assign c1_o = c1[0];

endmodule

`default_nettype wire

/* rtl/core/free_list_allocator_unit.sv */
// Free list allocator top level: config registers, sequencer, counters, result register.
// Depends on fla_pkg, fla_if and fla_chain.
//
//   channel   dir  handshake      content
//   in_ch     in   valid/ready    opcode, req_bytes, rel_start
//   out_ch    out  valid/ready    status, grant, running counters
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// One item at a time. Every search runs through the 65-cell chain after a decode step.
// Buddy adds a power-of-two search before the scan and a halving pass after it; a release
// adds a wait and a merge step per merged pair.
// Reset clears counters and empties the table; an init item loads the pool as one extent.
// A result waiting on out_ch does not block the next item; only its finish waits.
`default_nettype none

module free_list_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  fla_in_if.sink      in_ch,
  fla_out_if.source   out_ch
);
  import fla_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POW, S_SCAN, S_ACT, S_BCOUNT, S_BSPLIT, S_MWAIT, S_MERGE, S_DONE
  } state_e;

  state_e               state_q;
  logic [1:0]           op_q;
  logic [DW-1:0]        req_q, rs_q;
  logic [1:0]           strat_q;
  logic [3:0]           align_q;
  logic [16:0]          minreq_q;
  logic [DW-1:0]        pool_q;
  logic [DW-1:0]        size_q;
  logic [DW:0]          p_q;
  logic [CNT_W-1:0]     held_q;
  logic [DW-1:0]        used_q, free_q, grants_q, rels_q;
  scan_mode_e           mode_q;
  logic [DW-1:0]        key_q;
  logic [IDX_W-1:0]     scnt_q;
  cell_cmd_t            cmd_q;
  logic [IDX_W-1:0]     pk_idx_q;
  logic [DW-1:0]        pk_start_q, pk_len_q, cur_q;
  logic [NSPLIT_W-1:0]  n_q;
  logic                 first_q;
  logic [1:0]           res_st_q;
  logic [DW-1:0]        res_gs_q, res_gb_q;

  logic                 out_valid_q;
  logic [1:0]           out_st_q;
  logic [DW-1:0]        out_gs_q, out_gb_q, out_used_q, out_free_q, out_gr_q, out_rel_q;
  logic [6:0]           out_cnt_q;

  scan_ctl_t            ctl;
  cand_t                c0, c1, bud;
  merge_t               merge;

  logic [3:0]           a_eff;
  logic [12:0]          amask;
  logic [DW:0]          alignv, rnd;
  logic [DW-1:0]        szm, sz1, best_diff, half;
  logic                 best_split, touch_l, touch_r, half_ok, over;
  logic [IDX_W-1:0]     rel_pos;
  logic [CNT_W:0]       need;

  assign ctl = '{mode: mode_q, key: key_q, held: held_q};

  fla_chain u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .cmd_i   (cmd_q),
    .c0_o    (c0),
    .c1_o    (c1),
    .merge_o (merge)
  );

  always_comb begin
    a_eff      = (align_q > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : align_q;
    amask      = 13'((13'd1 << a_eff) - 13'd1);
    alignv     = {20'd0, amask} + (DW+1)'(1);
    szm        = (req_q < {15'd0, minreq_q}) ? {15'd0, minreq_q} : req_q;
    sz1        = (szm == '0) ? DW'(1) : szm;
    rnd        = ({1'b0, sz1} + {20'd0, amask}) & ~{20'd0, amask};
    best_diff  = c0.len - size_q;
    best_split = {1'b0, best_diff} > alignv;
    touch_l    = c0.found && (({1'b0, c0.start} + {1'b0, c0.len}) == {1'b0, rs_q});
    touch_r    = c1.found && (({1'b0, rs_q} + {1'b0, req_q}) == {1'b0, c1.start});
    rel_pos    = c0.found ? c0.idx + IDX_W'(1) : '0;
    bud        = c0.found ? c0 : c1;
    half       = cur_q >> 1;
    half_ok    = {1'b0, half} >= p_q;
    need       = {1'b0, held_q} - (CNT_W+1)'(1) + (CNT_W+1)'(n_q);
    over       = need > (CNT_W+1)'(MAX_EXTENTS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ALLOC;
      req_q       <= '0;
      rs_q        <= '0;
      strat_q     <= STRAT_BEST;
      align_q     <= 4'd4;
      minreq_q    <= 17'd256;
      pool_q      <= 32'd268435456;
      size_q      <= '0;
      p_q         <= '0;
      held_q      <= '0;
      used_q      <= '0;
      free_q      <= '0;
      grants_q    <= '0;
      rels_q      <= '0;
      mode_q      <= SCAN_FIRST;
      key_q       <= '0;
      scnt_q      <= '0;
      cmd_q       <= CMD_IDLE;
      pk_idx_q    <= '0;
      pk_start_q  <= '0;
      pk_len_q    <= '0;
      cur_q       <= '0;
      n_q         <= '0;
      first_q     <= 1'b0;
      res_st_q    <= ST_OK;
      res_gs_q    <= '0;
      res_gb_q    <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_gs_q    <= '0;
      out_gb_q    <= '0;
      out_used_q  <= '0;
      out_free_q  <= '0;
      out_cnt_q   <= '0;
      out_gr_q    <= '0;
      out_rel_q   <= '0;
    end else begin
      cmd_q <= CMD_IDLE;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STRATEGY: strat_q  <= cfg_wdata_i[1:0];
          CFG_ALIGN:    align_q  <= cfg_wdata_i[3:0];
          CFG_MIN_REQ:  minreq_q <= cfg_wdata_i[16:0];
          CFG_POOL:     pool_q   <= cfg_wdata_i;
          default:      pool_q   <= pool_q;
        endcase
      end

      if (out_valid_q && out_ch.ready && state_q != S_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_q     <= in_ch.opcode;
            req_q    <= in_ch.req_bytes;
            rs_q     <= in_ch.rel_start;
            res_st_q <= ST_OK;
            res_gs_q <= '0;
            res_gb_q <= '0;
            state_q  <= S_DECODE;
          end
        end

        S_DECODE: begin
          scnt_q <= '0;
          unique case (op_q)
            OP_ALLOC: begin
              if (rnd[DW]) begin
                res_st_q <= ST_NOFIT;
                state_q  <= S_DONE;
              end else begin
                size_q <= rnd[DW-1:0];
                if (strat_q == STRAT_BUDDY) begin
                  p_q     <= (DW+1)'(1);
                  state_q <= S_POW;
                end else begin
                  mode_q  <= (strat_q == STRAT_FIRST) ? SCAN_FIRST : SCAN_BEST;
                  key_q   <= rnd[DW-1:0];
                  state_q <= S_SCAN;
                end
              end
            end
            OP_RELEASE: begin
              if (req_q == '0) begin
                rels_q  <= rels_q + 32'd1;
                state_q <= S_DONE;
              end else begin
                mode_q  <= SCAN_REL;
                key_q   <= rs_q;
                state_q <= S_SCAN;
              end
            end
            OP_INIT: begin
              cmd_q    <= '{op: CMD_WRITE, idx: '0, start: '0, len: pool_q};
              held_q   <= (pool_q != '0) ? CNT_W'(1) : '0;
              used_q   <= '0;
              free_q   <= pool_q;
              grants_q <= '0;
              rels_q   <= '0;
              state_q  <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end

        S_POW: begin
          if (p_q >= {1'b0, size_q}) begin
            if (p_q[DW]) begin
              res_st_q <= ST_NOFIT;
              state_q  <= S_DONE;
            end else begin
              mode_q  <= SCAN_BUDDY;
              key_q   <= p_q[DW-1:0];
              state_q <= S_SCAN;
            end
          end else begin
            p_q <= p_q << 1;
          end
        end

        S_SCAN: begin
          if (scnt_q == IDX_W'(NCELL - 1)) state_q <= S_ACT;
          else scnt_q <= scnt_q + IDX_W'(1);
        end

        S_ACT: begin
          if (op_q == OP_RELEASE) begin
            if (held_q >= CNT_W'(MAX_EXTENTS) && !touch_l && !touch_r) begin
              res_st_q <= ST_FULL;
              state_q  <= S_DONE;
            end else begin
              cmd_q   <= '{op: CMD_INS, idx: rel_pos, start: rs_q, len: req_q};
              held_q  <= held_q + CNT_W'(1);
              used_q  <= used_q - req_q;
              free_q  <= free_q + req_q;
              rels_q  <= rels_q + 32'd1;
              state_q <= S_MWAIT;
            end
          end else begin
            case (strat_q)
              STRAT_FIRST: begin
                if (!c0.found) begin
                  res_st_q <= ST_NOFIT;
                end else begin
                  res_gs_q <= c0.start;
                  res_gb_q <= size_q;
                  used_q   <= used_q + size_q;
                  free_q   <= free_q - size_q;
                  grants_q <= grants_q + 32'd1;
                  if (c0.len == size_q) begin
                    cmd_q  <= '{op: CMD_DEL, idx: c0.idx, start: '0, len: '0};
                    held_q <= held_q - CNT_W'(1);
                  end else begin
                    cmd_q <= '{op: CMD_WRITE, idx: c0.idx, start: c0.start + size_q,
                               len: c0.len - size_q};
                  end
                end
                state_q <= S_DONE;
              end
              STRAT_BUDDY: begin
                if (!bud.found) begin
                  res_st_q <= ST_NOFIT;
                  state_q  <= S_DONE;
                end else begin
                  pk_idx_q   <= bud.idx;
                  pk_start_q <= bud.start;
                  pk_len_q   <= bud.len;
                  cur_q      <= bud.len;
                  n_q        <= '0;
                  state_q    <= S_BCOUNT;
                end
              end
              default: begin
                if (!c0.found) begin
                  res_st_q <= ST_NOFIT;
                end else begin
                  res_gs_q <= c0.start;
                  grants_q <= grants_q + 32'd1;
                  if (best_split) begin
                    res_gb_q <= size_q;
                    used_q   <= used_q + size_q;
                    free_q   <= free_q - size_q;
                    cmd_q    <= '{op: CMD_WRITE, idx: c0.idx, start: c0.start + size_q,
                                  len: best_diff};
                  end else begin
                    res_gb_q <= c0.len;
                    used_q   <= used_q + c0.len;
                    free_q   <= free_q - c0.len;
                    cmd_q    <= '{op: CMD_DEL, idx: c0.idx, start: '0, len: '0};
                    held_q   <= held_q - CNT_W'(1);
                  end
                end
                state_q <= S_DONE;
              end
            endcase
          end
        end

        S_BCOUNT: begin
          if (half_ok) begin
            n_q   <= n_q + NSPLIT_W'(1);
            cur_q <= half;
          end else if (over) begin
            res_st_q <= ST_FULL;
            state_q  <= S_DONE;
          end else begin
            cur_q   <= pk_len_q;
            first_q <= 1'b1;
            state_q <= S_BSPLIT;
          end
        end

        S_BSPLIT: begin
          if (half_ok) begin
            cmd_q <= '{op: first_q ? CMD_WRITE : CMD_INS, idx: pk_idx_q,
                       start: pk_start_q + half, len: cur_q - half};
            if (!first_q) held_q <= held_q + CNT_W'(1);
            first_q <= 1'b0;
            cur_q   <= half;
          end else begin
            if (first_q) begin
              cmd_q  <= '{op: CMD_DEL, idx: pk_idx_q, start: '0, len: '0};
              held_q <= held_q - CNT_W'(1);
            end
            res_gs_q <= pk_start_q;
            res_gb_q <= cur_q;
            used_q   <= used_q + cur_q;
            free_q   <= free_q - cur_q;
            grants_q <= grants_q + 32'd1;
            state_q  <= S_DONE;
          end
        end

        S_MWAIT: state_q <= S_MERGE;

        S_MERGE: begin
          if (merge.any) begin
            cmd_q   <= '{op: CMD_MERGE, idx: merge.idx, start: '0, len: '0};
            held_q  <= held_q - CNT_W'(1);
            state_q <= S_MWAIT;
          end else begin
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_st_q    <= res_st_q;
            out_gs_q    <= res_gs_q;
            out_gb_q    <= res_gb_q;
            out_used_q  <= used_q;
            out_free_q  <= free_q;
            out_cnt_q   <= 7'(held_q);
            out_gr_q    <= grants_q;
            out_rel_q   <= rels_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state_q == S_IDLE);
  assign out_ch.valid         = out_valid_q;
  assign out_ch.status        = out_st_q;
  assign out_ch.grant_start   = out_gs_q;
  assign out_ch.grant_bytes   = out_gb_q;
  assign out_ch.bytes_used    = out_used_q;
  assign out_ch.bytes_free    = out_free_q;
  assign out_ch.extent_count  = out_cnt_q;
  assign out_ch.grant_total   = out_gr_q;
  assign out_ch.release_total = out_rel_q;

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(NCELL))
    else $error("extent count beyond chain length");

  a_held_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (held_q <= CNT_W'(MAX_EXTENTS)))
    else $error("extent table over capacity at item end");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q != ST_OK) |-> (out_gs_q == '0 && out_gb_q == '0))
    else $error("grant fields set on failed item");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");

endmodule

`default_nettype wire
